// ===== src/obcd_pkg.sv =====
// ---------------------------------------------------------------------------
// obcd_pkg: shared types and constants of the one-button countdown timer
// Field widths, state codes, register indexes and the control bundle that
// passes from the register block to the timer engine.
// ---------------------------------------------------------------------------
package obcd_pkg;

   // Field widths.
   localparam int DUR_W    = 27;
   localparam int HOLD_W   = 16;
   localparam int STATE_W  = 2;
   localparam int IDX_W    = 8;
   localparam int CSR_W    = 32;
   localparam int REQ_W    = 8;
   localparam int RSP_W    = 32;

   // Blink timing: the digits are shown for the first half of each period.
   localparam int BLINK_HALF_MS = 500;
   localparam int BLINK_W       = $clog2(2 * BLINK_HALF_MS);
   localparam logic [BLINK_W-1:0] BLINK_HALF = BLINK_W'(BLINK_HALF_MS);
   localparam logic [BLINK_W-1:0] BLINK_LAST = BLINK_W'(2 * BLINK_HALF_MS - 1);

   // Reset values of the configuration registers.
   localparam logic [DUR_W-1:0]  DURATION_RESET   = DUR_W'(5000);
   localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = HOLD_W'(1000);
   localparam logic [HOLD_W-1:0] HOLD_MAX         = '1;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_DURATION   = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_LONG_PRESS = IDX_W'(1);

   // Timer states as they appear on the result channel.
   typedef enum logic [STATE_W-1:0] {
      ST_STOPPED  = 2'd0,
      ST_RUNNING  = 2'd1,
      ST_PAUSED   = 2'd2,
      ST_FINISHED = 2'd3
   } run_state_type;

   // Configuration as seen by the engine.
   typedef struct packed {
      logic [DUR_W-1:0]  duration;
      logic [HOLD_W-1:0] long_press;
      logic              clear_timer;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic          show_time;
      run_state_type timer_state;
      logic [DUR_W-1:0] remaining_ms;
   } result_type;

endpackage

// ===== src/obcd_csr.sv =====
// ---------------------------------------------------------------------------
// obcd_csr: configuration registers
// Holds the countdown length and the long-press time, and flags a duration
// write so that the engine returns the timer to stopped.
// ---------------------------------------------------------------------------
module obcd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [obcd_pkg::IDX_W-1:0]   csr_index,
   input  logic [obcd_pkg::CSR_W-1:0]   csr_data,
   output obcd_pkg::cfg_type            cfg
);

   logic [obcd_pkg::DUR_W-1:0]  duration_ff;
   logic [obcd_pkg::HOLD_W-1:0] long_press_ff;
   logic                        wr_en;

   // Writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff   <= obcd_pkg::DURATION_RESET;
         long_press_ff <= obcd_pkg::LONG_PRESS_RESET;
      end else if (wr_en) begin
         if (csr_index == obcd_pkg::REG_DURATION) begin
            duration_ff <= csr_data[obcd_pkg::DUR_W-1:0];
         end
         if (csr_index == obcd_pkg::REG_LONG_PRESS) begin
            long_press_ff <= csr_data[obcd_pkg::HOLD_W-1:0];
         end
      end
   end

   assign cfg.duration    = duration_ff;
   assign cfg.long_press  = long_press_ff;
   assign cfg.clear_timer = wr_en && (csr_index == obcd_pkg::REG_DURATION);

endmodule

// ===== src/obcd_engine.sv =====
// ---------------------------------------------------------------------------
// obcd_engine: timer state and per-tick update
// Advances the countdown, tracks the button press and forms the result of
// each tick from the updated state in one pass of logic.
// ---------------------------------------------------------------------------
module obcd_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick_en,
   input  logic                   level,
   input  obcd_pkg::cfg_type      cfg,
   output obcd_pkg::result_type   result
);

   obcd_pkg::run_state_type         run_ff, run_in;
   logic [obcd_pkg::DUR_W-1:0]      elapsed_ff, elapsed_in;
   logic                            prev_level_ff;
   logic                            armed_ff, armed_in;
   logic [obcd_pkg::HOLD_W-1:0]     hold_ff, hold_in;
   logic [obcd_pkg::BLINK_W-1:0]    blink_ff, blink_in;
   logic [obcd_pkg::DUR_W-1:0]      elapsed_inc;
   logic                            falling, rising;

   assign falling     = !level && prev_level_ff;
   assign rising      = level && !prev_level_ff;
   assign elapsed_inc = elapsed_ff + obcd_pkg::DUR_W'(1);

   // Time step, then button step, for the tick being taken.
   always_comb begin
      run_in     = run_ff;
      elapsed_in = elapsed_ff;
      armed_in   = armed_ff;
      hold_in    = hold_ff;

      if (run_ff == obcd_pkg::ST_RUNNING) begin
         if (elapsed_inc >= cfg.duration) begin
            elapsed_in = cfg.duration;
            run_in     = obcd_pkg::ST_FINISHED;
         end else begin
            elapsed_in = elapsed_inc;
         end
      end

      if (falling) begin
         armed_in = 1'b1;
         hold_in  = '0;
      end else if (!level && armed_ff && (hold_ff != obcd_pkg::HOLD_MAX)) begin
         hold_in = hold_ff + obcd_pkg::HOLD_W'(1);
      end

      // A held press resets the timer once the hold time is reached.
      if (!level && armed_in && (hold_in >= cfg.long_press)) begin
         run_in     = obcd_pkg::ST_STOPPED;
         elapsed_in = '0;
         armed_in   = 1'b0;
      end

      // Short tap on release.
      if (rising && armed_in) begin
         case (run_in)
            obcd_pkg::ST_FINISHED: begin
               run_in     = obcd_pkg::ST_STOPPED;
               elapsed_in = '0;
            end
            obcd_pkg::ST_RUNNING: run_in = obcd_pkg::ST_PAUSED;
            default:              run_in = obcd_pkg::ST_RUNNING;
         endcase
         armed_in = 1'b0;
      end
   end

   // Free-running blink phase.
   assign blink_in = (blink_ff >= obcd_pkg::BLINK_LAST) ? '0
                                                       : blink_ff + obcd_pkg::BLINK_W'(1);

   // Result of this tick, from the updated state.
   always_comb begin
      result.timer_state = run_in;
      result.show_time   = 1'b1;
      case (run_in)
         obcd_pkg::ST_STOPPED:  result.remaining_ms = cfg.duration;
         obcd_pkg::ST_FINISHED: begin
            result.remaining_ms = '0;
            result.show_time    = (blink_ff < obcd_pkg::BLINK_HALF);
         end
         default: begin
            result.remaining_ms = (elapsed_in <= cfg.duration) ?
                                  cfg.duration - elapsed_in : '0;
         end
      endcase
   end

   // State registers; a duration write returns the timer to stopped.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= obcd_pkg::ST_STOPPED;
         elapsed_ff    <= '0;
         prev_level_ff <= 1'b1;
         armed_ff      <= 1'b0;
         hold_ff       <= '0;
         blink_ff      <= '0;
      end else if (cfg.clear_timer) begin
         run_ff     <= obcd_pkg::ST_STOPPED;
         elapsed_ff <= '0;
      end else if (tick_en) begin
         run_ff        <= run_in;
         elapsed_ff    <= elapsed_in;
         prev_level_ff <= level;
         armed_ff      <= armed_in;
         hold_ff       <= hold_in;
         blink_ff      <= blink_in;
      end
   end

   // The elapsed count never passes the duration.
   a_elapsed_bound: assert property (@(posedge clock) disable iff (reset)
      elapsed_ff <= cfg.duration)
      else $error("elapsed count beyond duration");

   // A stopped timer has no elapsed time.
   a_stopped_zero: assert property (@(posedge clock) disable iff (reset)
      (run_ff == obcd_pkg::ST_STOPPED) |-> (elapsed_ff == '0))
      else $error("stopped timer with elapsed time");

   // A falling edge on an accepted tick arms the press with a fresh hold count.
   a_fall_arms: assert property (@(posedge clock) disable iff (reset)
      (tick_en && falling && !cfg.clear_timer && (cfg.long_press != '0))
      |=> (armed_ff && (hold_ff == '0)))
      else $error("falling edge did not arm the press");

endmodule

// ===== src/one_button_countdown_timer_core.sv =====
// ---------------------------------------------------------------------------
// one_button_countdown_timer_core: one-button countdown timer
// Takes one millisecond tick with the sampled button level per transfer and
// returns the remaining time, timer state and blink flag of that tick.
//
//   Channel | Direction | Ports                  | Content
//   req     | in        | req_tvalid/tready/tdata | one tick, button level
//   rsp     | out       | rsp_tvalid/tready/tdata | remaining, state, show flag
//   csr     | in        | csr_valid/ready/index/data | register writes
//
// The whole update is one pass of logic between the timer state registers
// and the result register, so a tick is accepted in every cycle while the
// result register is empty or being drained. The result is registered and
// appears in the cycle after its tick is accepted. Reset is synchronous
// and returns the timer to stopped with the reset register values. When the
// result side stalls, the result register holds and no further tick is accepted.
// ---------------------------------------------------------------------------
module one_button_countdown_timer_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [obcd_pkg::REQ_W-1:0]  req_tdata,  // [0] button_level, [7:1] zero
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [obcd_pkg::RSP_W-1:0]  rsp_tdata,  // [26:0] remaining_ms,
                                                   // [28:27] timer_state,
                                                   // [29] show_time, [31:30] zero
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [obcd_pkg::IDX_W-1:0]  csr_index,
   input  logic [obcd_pkg::CSR_W-1:0]  csr_data
);

   obcd_pkg::cfg_type    cfg;
   obcd_pkg::result_type result;
   obcd_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 tick_en;

   // A tick is taken whenever the result register is free this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign tick_en    = req_tvalid && req_tready;

   obcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   obcd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .level   (req_tdata[0]),
      .cfg     (cfg),
      .result  (result)
   );

   // Result register.
   assign rsp_valid_in = tick_en || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_en) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(obcd_pkg::RSP_W - $bits(obcd_pkg::result_type)){1'b0}}, rsp_data_ff};

   // A finished timer always reports no time left.
   a_finished_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.timer_state == obcd_pkg::ST_FINISHED))
      |-> (rsp_data_ff.remaining_ms == '0))
      else $error("finished result with time left");

endmodule

// ===== tb/one_button_countdown_timer_core_tb.sv =====
// ---------------------------------------------------------------------------
// one_button_countdown_timer_core_tb: self-checking bench of the countdown timer
// Sends millisecond ticks with a button level, predicts the remaining time,
// state and blink flag of each tick, and checks every result transfer in order.
// Directed taps and holds come first, then random press sequences under
// several register settings, with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module one_button_countdown_timer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import obcd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '1;  // [0] button_level, [7:1] zero
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;       // [26:0] remaining_ms, [28:27] timer_state,
                                        // [29] show_time, [31:30] zero
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]   csr_data = '0;

   // Timer as the bench expects it to be.
   logic [DUR_W-1:0]   cfg_duration;
   logic [HOLD_W-1:0]  cfg_long_press;
   run_state_type      tmr_state;
   logic [DUR_W-1:0]   elapsed;
   logic               prev_level;
   logic               armed;
   logic [HOLD_W-1:0]  hold;
   int unsigned        blink;

   result_type         due_readouts[$];
   int                 mismatch_count = 0;
   int                 readout_count = 0;
   int                 quiet_cycles = 0;

   // Idling controls shared between the test tasks and the channel processes.
   bit                 gaps_on = 1'b1;
   bit                 stalls_on = 1'b1;
   int                 rsp_hold_req = 0;
   int                 stall_left = 0;
   int                 stall_roll;

   one_button_countdown_timer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the result of one tick and moves the expected timer on.
   function automatic result_type advance_timer(input logic level);
      result_type r;
      // The time step comes before the button is looked at.
      if (tmr_state == ST_RUNNING) begin
         elapsed = elapsed + 1'b1;
         if (elapsed >= cfg_duration) begin
            elapsed   = cfg_duration;
            tmr_state = ST_FINISHED;
         end
      end
      // Button step: arm on a press, count the hold, act on a release.
      if (!level && prev_level) begin
         armed = 1'b1;
         hold  = '0;
      end else if (!level && armed) begin
         if (hold != HOLD_MAX)
            hold = hold + 1'b1;
      end
      if (!level && armed && hold >= cfg_long_press) begin
         tmr_state = ST_STOPPED;
         elapsed   = '0;
         armed     = 1'b0;
      end
      if (level && !prev_level && armed) begin
         if (tmr_state == ST_FINISHED) begin
            tmr_state = ST_STOPPED;
            elapsed   = '0;
         end else if (tmr_state == ST_RUNNING) begin
            tmr_state = ST_PAUSED;
         end else begin
            tmr_state = ST_RUNNING;
         end
         armed = 1'b0;
      end
      prev_level = level;
      // The blink flag uses the phase from before this tick's advance.
      r.timer_state = tmr_state;
      if (tmr_state == ST_STOPPED)
         r.remaining_ms = cfg_duration;
      else if (tmr_state == ST_FINISHED)
         r.remaining_ms = '0;
      else
         r.remaining_ms = (elapsed <= cfg_duration) ? cfg_duration - elapsed : '0;
      r.show_time = (tmr_state == ST_FINISHED) ? (blink < BLINK_HALF_MS) : 1'b1;
      blink = (blink + 1 >= 2 * BLINK_HALF_MS) ? 0 : blink + 1;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 65)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on result %0d: %s is %0h, expected %0h",
               readout_count, what, got, want);
      mismatch_count++;
   endtask

   // Offers one tick and records its expected result once the transfer happens.
   task automatic send_tick(input logic level);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-1){1'b0}}, level};
      do @(posedge clock); while (!req_tready);
      due_readouts.push_back(advance_timer(level));
   endtask

   // Stops offering ticks and waits until every result has come back.
   task automatic settle_timer();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_readouts.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == REG_DURATION) begin
         cfg_duration = value[DUR_W-1:0];
         tmr_state    = ST_STOPPED;
         elapsed      = '0;
      end else if (index == REG_LONG_PRESS) begin
         cfg_long_press = value[HOLD_W-1:0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_levels(input logic [31:0] levels, input int count);
      for (int i = 0; i < count; i++)
         send_tick(levels[i]);
   endtask

   // Short taps start and pause the timer with the reset settings.
   task automatic test_taps();
      send_levels(32'b1011_1011, 8);
   endtask

   // A zero hold time resets on the tick of the press itself.
   task automatic test_zero_long_press();
      settle_timer();
      write_register(REG_LONG_PRESS, 32'd2);
      write_register(REG_DURATION, 32'd3);
      send_levels(32'b10, 2);
      settle_timer();
      write_register(REG_LONG_PRESS, 32'd0);
      send_levels(32'b10, 2);
      send_tick(1'b1);
   endtask

   // Zero duration finishes at once; a long hold resets and its release is ignored.
   task automatic test_zero_duration();
      settle_timer();
      write_register(REG_DURATION, 32'd0);
      write_register(REG_LONG_PRESS, 32'd2);
      send_levels(32'b1_0001_0110, 9);
   endtask

   // All-ones writes are cut to the register widths; unknown indexes do nothing.
   task automatic test_register_extremes();
      settle_timer();
      write_register(REG_DURATION, 32'hFFFF_FFFF);
      write_register(REG_LONG_PRESS, 32'hFFFF_FFFF);
      write_register(IDX_W'(2), 32'hFFFF_FFFF);
      write_register('1, 32'h0);
      send_levels(32'b1110, 4);
   endtask

   // Random press sequences: released stretches, taps, long holds and noise.
   task automatic test_random_taps(input int count, input int duration, input int long_press,
                                   input int long_pct, input bit idling);
      int sent;
      int run_len;
      int roll;
      settle_timer();
      write_register(REG_DURATION, duration);
      write_register(REG_LONG_PRESS, long_press);
      gaps_on   = idling;
      stalls_on = idling;
      sent = 0;
      while (sent < count) begin
         run_len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(450, 650)
                                                      : $urandom_range(1, 15);
         for (int i = 0; i < run_len && sent < count; i++, sent++)
            send_tick(1'b1);
         roll = $urandom_range(0, 99);
         if (roll < 70)
            run_len = $urandom_range(1, 3);
         else if (roll < 92)
            run_len = (long_press > 37) ? $urandom_range(4, 40)
                                        : long_press + $urandom_range(0, 2);
         else
            run_len = $urandom_range(1, 12);
         for (int i = 0; i < run_len && sent < count; i++, sent++)
            send_tick((roll < 92) ? 1'b0 : 1'($urandom_range(0, 1)));
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while ticks keep coming.
   task automatic test_output_stall();
      settle_timer();
      rsp_hold_req = 60;
      test_random_taps(400, 3, 2, 10, 1'b1);
   endtask

   // Result channel readiness, with random stalls and requested long holds.
   always @(negedge clock) begin
      if (rsp_hold_req > 0) begin
         stall_left   = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (stalls_on) begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 12)
               stall_left = $urandom_range(1, 3);
            else if (stall_roll < 14)
               stall_left = $urandom_range(8, 30);
         end
      end
   end

   // Each result transfer is checked against the oldest expected result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_type got;
         result_type want;
         got = result_type'(rsp_tdata[29:0]);
         if (due_readouts.size() == 0) begin
            report_mismatch("unexpected result, data", rsp_tdata, 0);
         end else begin
            want = due_readouts.pop_front();
            if (got.remaining_ms !== want.remaining_ms)
               report_mismatch("remaining_ms", got.remaining_ms, want.remaining_ms);
            if (got.timer_state !== want.timer_state)
               report_mismatch("timer_state", got.timer_state, want.timer_state);
            if (got.show_time !== want.show_time)
               report_mismatch("show_time", got.show_time, want.show_time);
         end
         readout_count++;
      end
   end

   // Watchdog: ends the run if no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", quiet_cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      cfg_duration   = DURATION_RESET;
      cfg_long_press = LONG_PRESS_RESET;
      tmr_state      = ST_STOPPED;
      elapsed        = '0;
      prev_level     = 1'b1;
      armed          = 1'b0;
      hold           = '0;
      blink          = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_taps();
      test_zero_long_press();
      test_zero_duration();
      test_register_extremes();
      test_random_taps(100, 0, 0, 5, 1'b1);
      test_random_taps(400, 12, 4, 12, 1'b1);
      test_random_taps(300, 1000, 65535, 15, 1'b0);
      test_random_taps(150, 86400000, 1, 5, 1'b1);
      test_output_stall();
      test_random_taps(175, 40, 8, 10, 1'b1);

      settle_timer();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && due_readouts.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
src/obcd_pkg.sv
src/obcd_csr.sv
src/obcd_engine.sv
src/one_button_countdown_timer_core.sv
tb/one_button_countdown_timer_core_tb.sv
